>>> rtl/i2cts_pkg.sv
// Package for the I2C timing register solver.
// Holds widths, bus timing tables, status codes and tdata width constants.
// No dependencies; used by i2c_timing_register_solver.
package i2cts_pkg;

   // request field widths
   localparam int CLK_W  = 28;
   localparam int MODE_W = 2;
   localparam int DNF_W  = 4;

   // tdata widths, padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;

   // datapath widths
   localparam int T_W    = 40;  // clock period in ps, up to 1e12
   localparam int ACC_W  = 45;  // scaled periods, up to 16e12
   localparam int NUM_W  = 24;  // per-prescaler dividends, below 5e6
   localparam int CNT_W  = 6;   // divider iteration counter
   localparam int MULC_W = 5;   // filter period multiplier, up to 19
   localparam int TIME_W = 24;  // bus timing limits in ps

   localparam logic [T_W-1:0]  PS_PER_SECOND = 40'd1000000000000;
   localparam logic [CNT_W-1:0] T_DIV_STEPS  = 6'd40;
   localparam logic [CNT_W-1:0] P_DIV_STEPS  = 6'd24;

   // analog filter delay limits
   localparam logic [TIME_W-1:0] AF_MIN_PS = 24'd50000;
   localparam logic [TIME_W-1:0] AF_MAX_PS = 24'd260000;

   // register field limits
   localparam logic [NUM_W-1:0] DELAY_MAX   = 24'd15;
   localparam logic [NUM_W-1:0] SCL_Q_MAX   = 24'd16;
   localparam logic [NUM_W-1:0] COUNT_MAX   = 24'd255;
   localparam logic [3:0]       PRESC_LAST  = 4'd15;

   // speed modes
   localparam logic [MODE_W-1:0] MODE_STANDARD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FAST      = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FAST_PLUS = 2'd2;
   localparam logic [MODE_W-1:0] MODE_INVALID   = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_ARG = 2'd1,
      STATUS_NO_FIT  = 2'd2
   } status_type;

   // data hold time maximum (hold minimum is zero in every mode)
   function automatic logic [TIME_W-1:0] hd_dat_max_ps(input logic [MODE_W-1:0] mode);
      case (mode)
         MODE_STANDARD:  hd_dat_max_ps = 24'd3450000;
         MODE_FAST:      hd_dat_max_ps = 24'd900000;
         MODE_FAST_PLUS: hd_dat_max_ps = 24'd450000;
         default:        hd_dat_max_ps = '0;
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] fall_max_ps(input logic [MODE_W-1:0] mode);
      case (mode)
         MODE_STANDARD:  fall_max_ps = 24'd300000;
         MODE_FAST:      fall_max_ps = 24'd300000;
         MODE_FAST_PLUS: fall_max_ps = 24'd120000;
         default:        fall_max_ps = '0;
      endcase
   endfunction

   // rise time maximum plus data setup minimum
   function automatic logic [TIME_W-1:0] setup_need_ps(input logic [MODE_W-1:0] mode);
      case (mode)
         MODE_STANDARD:  setup_need_ps = 24'd1000000 + 24'd250000;
         MODE_FAST:      setup_need_ps = 24'd300000 + 24'd100000;
         MODE_FAST_PLUS: setup_need_ps = 24'd120000 + 24'd50000;
         default:        setup_need_ps = '0;
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] low_min_ps(input logic [MODE_W-1:0] mode);
      case (mode)
         MODE_STANDARD:  low_min_ps = 24'd4700000;
         MODE_FAST:      low_min_ps = 24'd1300000;
         MODE_FAST_PLUS: low_min_ps = 24'd500000;
         default:        low_min_ps = '0;
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] high_min_ps(input logic [MODE_W-1:0] mode);
      case (mode)
         MODE_STANDARD:  high_min_ps = 24'd4000000;
         MODE_FAST:      high_min_ps = 24'd600000;
         MODE_FAST_PLUS: high_min_ps = 24'd260000;
         default:        high_min_ps = '0;
      endcase
   endfunction

endpackage

>>> rtl/i2c_timing_register_solver.sv
// I2C timing register solver: derives bus timing register fields from a clock.
// Depends on i2cts_pkg (widths, timing tables, status codes).
//
// Usage:
//  - Request channel req_*: one request carries the kernel clock in Hz, the
//    speed mode, the analog filter enable and the digital filter length.
//    req_tready is high only while the solver is idle; one request at a time.
//  - Response channel rsp_*: exactly one response per request, holding the
//    status, the packed timing word, its fields and the filter control bits.
//  - Timing: a bad argument skips the search. Otherwise the clock period is
//    found on the bit-serial divider, the filter delays by repeated addition,
//    and each of up to 16 prescaler trials takes up to five divisions on the
//    single shared restoring divider, which gives one quotient bit per cycle.
//  - Stall: the response sits in an output register until rsp_tready; the
//    solver may take the next request meanwhile, and holds a finished result
//    until the output register is free.
//  - Reset (synchronous, active high): returns to idle, drops rsp_tvalid.
module i2c_timing_register_solver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // clock_hz[27:0], speed_mode[29:28], analog_filter_on[30], filter_length[34:31]
   input  logic [i2cts_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status[1:0], timing_word[33:2], prescaler[37:34], clock_delay[41:38],
   // data_delay[45:42], high_count[53:46], low_count[61:54],
   // analog_filter_off[62], filter_length_out[66:63]
   output logic [i2cts_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIVT,
      S_MUL,
      S_PREP,
      S_LOAD,
      S_DIV,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      STEP_SDA_MAX,
      STEP_SDA_MIN,
      STEP_SCL,
      STEP_HIGH,
      STEP_LOW
   } step_type;

   state_type state_ff;
   step_type  step_ff;

   // request fields
   logic [i2cts_pkg::CLK_W-1:0]  clk_ff;
   logic [i2cts_pkg::MODE_W-1:0] mode_ff;
   logic                         af_ff;
   logic [i2cts_pkg::DNF_W-1:0]  dnf_ff;

   // period and scaled sums
   logic [i2cts_pkg::T_W-1:0]    t_ff;
   logic [i2cts_pkg::ACC_W-1:0]  tp_ff;
   logic [i2cts_pkg::ACC_W-1:0]  acc_min_ff;
   logic [i2cts_pkg::ACC_W-1:0]  acc_max_ff;
   logic [i2cts_pkg::MULC_W-1:0] mul_cnt_ff;
   logic                         mul_first_ff;

   // per-prescaler dividends and skip flags
   logic [i2cts_pkg::NUM_W-1:0]  num_sda_max_ff;
   logic [i2cts_pkg::NUM_W-1:0]  num_sda_min_ff;
   logic [i2cts_pkg::NUM_W-1:0]  num_scl_ff;
   logic [i2cts_pkg::NUM_W-1:0]  num_high_ff;
   logic [i2cts_pkg::NUM_W-1:0]  num_low_ff;
   logic                         skip_sda_min_ff;
   logic                         skip_high_ff;
   logic                         skip_low_ff;

   // bit-serial divider
   logic [i2cts_pkg::ACC_W-1:0]  div_rem_ff;
   logic [i2cts_pkg::T_W-1:0]    div_num_ff;
   logic [i2cts_pkg::T_W-1:0]    div_q_ff;
   logic [i2cts_pkg::CNT_W-1:0]  div_cnt_ff;

   // trial results
   logic [3:0]                   p_ff;
   logic [i2cts_pkg::NUM_W-1:0]  sda_max_ff;
   logic [3:0]                   sda_min_ff;
   logic [3:0]                   scl_ff;
   logic [i2cts_pkg::NUM_W-1:0]  nh_ff;
   logic [7:0]                   n_ff;
   i2cts_pkg::status_type        status_ff;

   logic                         rsp_tvalid_ff;
   logic [i2cts_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;

   // request unpacking
   logic [i2cts_pkg::CLK_W-1:0]  req_clk;
   logic [i2cts_pkg::MODE_W-1:0] req_mode;
   logic                         req_af;
   logic [i2cts_pkg::DNF_W-1:0]  req_dnf;

   assign req_clk  = req_tdata[27:0];
   assign req_mode = req_tdata[29:28];
   assign req_af   = req_tdata[30];
   assign req_dnf  = req_tdata[34:31];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // output register takes a finished result
   logic rsp_load;

   assign rsp_load = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);

   // divider step: shift in one dividend bit, subtract when it fits
   logic [i2cts_pkg::ACC_W-1:0] div_den;
   logic [i2cts_pkg::ACC_W:0]   div_trial;
   logic [i2cts_pkg::ACC_W:0]   div_diff;
   logic                        div_ge;

   always_comb begin
      div_den   = (state_ff == S_DIVT) ?
                  {{(i2cts_pkg::ACC_W-i2cts_pkg::CLK_W){1'b0}}, clk_ff} : tp_ff;
      div_trial = {div_rem_ff, div_num_ff[i2cts_pkg::T_W-1]};
      div_diff  = div_trial - {1'b0, div_den};
      div_ge    = (div_trial >= {1'b0, div_den});
   end

   // mode limits and hold window check
   logic [i2cts_pkg::TIME_W-1:0] lim_hd_max;
   logic [i2cts_pkg::TIME_W-1:0] lim_fall;
   logic [i2cts_pkg::TIME_W-1:0] lim_setup;
   logic [i2cts_pkg::TIME_W-1:0] lim_high;
   logic [i2cts_pkg::TIME_W-1:0] lim_low;
   logic                         max_neg;

   always_comb begin
      lim_hd_max = i2cts_pkg::hd_dat_max_ps(mode_ff);
      lim_fall   = i2cts_pkg::fall_max_ps(mode_ff);
      lim_setup  = i2cts_pkg::setup_need_ps(mode_ff);
      lim_high   = i2cts_pkg::high_min_ps(mode_ff);
      lim_low    = i2cts_pkg::low_min_ps(mode_ff);
      max_neg    = acc_max_ff > {{(i2cts_pkg::ACC_W-i2cts_pkg::TIME_W){1'b0}}, lim_hd_max};
   end

   // dividend selection for the current step
   logic [i2cts_pkg::NUM_W-1:0] load_num;
   logic                        load_skip;

   always_comb begin
      case (step_ff)
         STEP_SDA_MAX: begin
            load_num  = num_sda_max_ff;
            load_skip = 1'b0;
         end
         STEP_SDA_MIN: begin
            load_num  = num_sda_min_ff;
            load_skip = skip_sda_min_ff;
         end
         STEP_SCL: begin
            load_num  = num_scl_ff;
            load_skip = 1'b0;
         end
         STEP_HIGH: begin
            load_num  = num_high_ff;
            load_skip = skip_high_ff;
         end
         STEP_LOW: begin
            load_num  = num_low_ff;
            load_skip = skip_low_ff;
         end
         default: begin
            load_num  = '0;
            load_skip = 1'b1;
         end
      endcase
   end

   // quotient checks
   logic [i2cts_pkg::NUM_W-1:0] quot;
   logic [i2cts_pkg::NUM_W-1:0] n_max;
   logic                        trial_reject;

   always_comb begin
      quot  = div_q_ff[i2cts_pkg::NUM_W-1:0];
      n_max = (nh_ff > quot) ? nh_ff : quot;
      trial_reject = (step_ff == STEP_SDA_MIN &&
                      (quot > sda_max_ff || quot > i2cts_pkg::DELAY_MAX)) ||
                     (step_ff == STEP_SCL && quot > i2cts_pkg::SCL_Q_MAX) ||
                     (step_ff == STEP_LOW && n_max > i2cts_pkg::COUNT_MAX);
   end

   // response word
   logic [i2cts_pkg::RSP_DATA_W-1:0] rsp_word;
   logic [31:0]                      timing_word;

   always_comb begin
      timing_word = {p_ff, 4'b0000, scl_ff, sda_min_ff, n_ff, n_ff};
      if (status_ff == i2cts_pkg::STATUS_OK) begin
         rsp_word = {5'b00000, dnf_ff, ~af_ff, n_ff, n_ff, sda_min_ff, scl_ff, p_ff,
                     timing_word, status_ff};
      end else begin
         rsp_word = {{(i2cts_pkg::RSP_DATA_W-2){1'b0}}, status_ff};
      end
   end

   // sequencer, divider and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  clk_ff     <= req_clk;
                  mode_ff    <= req_mode;
                  af_ff      <= req_af;
                  dnf_ff     <= req_dnf;
                  div_rem_ff <= '0;
                  div_q_ff   <= '0;
                  div_num_ff <= i2cts_pkg::PS_PER_SECOND;
                  div_cnt_ff <= i2cts_pkg::T_DIV_STEPS;
                  if (req_clk == '0 || req_mode == i2cts_pkg::MODE_INVALID) begin
                     status_ff <= i2cts_pkg::STATUS_BAD_ARG;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff  <= S_DIVT;
                  end
               end
            end

            // period = 1e12 / clock, one quotient bit per cycle
            S_DIVT: begin
               if (div_cnt_ff != '0) begin
                  div_rem_ff <= div_ge ? div_diff[i2cts_pkg::ACC_W-1:0] :
                                         div_trial[i2cts_pkg::ACC_W-1:0];
                  div_q_ff   <= {div_q_ff[i2cts_pkg::T_W-2:0], div_ge};
                  div_num_ff <= {div_num_ff[i2cts_pkg::T_W-2:0], 1'b0};
                  div_cnt_ff <= div_cnt_ff - 1'b1;
               end else begin
                  t_ff         <= div_q_ff;
                  tp_ff        <= {{(i2cts_pkg::ACC_W-i2cts_pkg::T_W){1'b0}}, div_q_ff};
                  acc_min_ff   <= {{(i2cts_pkg::ACC_W-i2cts_pkg::TIME_W){1'b0}},
                                   af_ff ? i2cts_pkg::AF_MIN_PS :
                                           {i2cts_pkg::TIME_W{1'b0}}};
                  acc_max_ff   <= {{(i2cts_pkg::ACC_W-i2cts_pkg::TIME_W){1'b0}},
                                   af_ff ? i2cts_pkg::AF_MAX_PS :
                                           {i2cts_pkg::TIME_W{1'b0}}};
                  mul_cnt_ff   <= {1'b0, dnf_ff} + 5'd4;
                  mul_first_ff <= 1'b1;
                  state_ff     <= S_MUL;
               end
            end

            // filter delays: (dnf+3)*t and (dnf+4)*t by repeated addition
            S_MUL: begin
               acc_max_ff <= acc_max_ff + {{(i2cts_pkg::ACC_W-i2cts_pkg::T_W){1'b0}}, t_ff};
               if (!mul_first_ff) begin
                  acc_min_ff <= acc_min_ff +
                                {{(i2cts_pkg::ACC_W-i2cts_pkg::T_W){1'b0}}, t_ff};
               end
               mul_first_ff <= 1'b0;
               mul_cnt_ff   <= mul_cnt_ff - 1'b1;
               if (mul_cnt_ff == 5'd1) begin
                  state_ff <= S_PREP;
               end
            end

            // dividends that do not depend on the prescaler
            S_PREP: begin
               num_sda_max_ff  <= lim_hd_max - acc_max_ff[i2cts_pkg::NUM_W-1:0];
               num_sda_min_ff  <= lim_fall - acc_min_ff[i2cts_pkg::NUM_W-1:0];
               num_scl_ff      <= lim_setup;
               num_high_ff     <= lim_high - acc_min_ff[i2cts_pkg::NUM_W-1:0] - 1'b1;
               num_low_ff      <= lim_low - acc_min_ff[i2cts_pkg::NUM_W-1:0] - 1'b1;
               skip_sda_min_ff <= acc_min_ff >
                                  {{(i2cts_pkg::ACC_W-i2cts_pkg::TIME_W){1'b0}}, lim_fall};
               skip_high_ff    <= acc_min_ff >=
                                  {{(i2cts_pkg::ACC_W-i2cts_pkg::TIME_W){1'b0}}, lim_high};
               skip_low_ff     <= acc_min_ff >=
                                  {{(i2cts_pkg::ACC_W-i2cts_pkg::TIME_W){1'b0}}, lim_low};
               p_ff            <= '0;
               step_ff         <= STEP_SDA_MAX;
               // hold window already used up: no prescaler can fit
               if (max_neg) begin
                  status_ff <= i2cts_pkg::STATUS_NO_FIT;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff  <= S_LOAD;
               end
            end

            // start one division by the scaled period; skipped ones give zero
            S_LOAD: begin
               div_rem_ff <= '0;
               div_q_ff   <= '0;
               div_num_ff <= {load_skip ? {i2cts_pkg::NUM_W{1'b0}} : load_num,
                              {(i2cts_pkg::T_W-i2cts_pkg::NUM_W){1'b0}}};
               div_cnt_ff <= load_skip ? '0 : i2cts_pkg::P_DIV_STEPS;
               state_ff   <= S_DIV;
            end

            S_DIV: begin
               if (div_cnt_ff != '0) begin
                  div_rem_ff <= div_ge ? div_diff[i2cts_pkg::ACC_W-1:0] :
                                         div_trial[i2cts_pkg::ACC_W-1:0];
                  div_q_ff   <= {div_q_ff[i2cts_pkg::T_W-2:0], div_ge};
                  div_num_ff <= {div_num_ff[i2cts_pkg::T_W-2:0], 1'b0};
                  div_cnt_ff <= div_cnt_ff - 1'b1;
               end else if (trial_reject) begin
                  // prescaler rejected: try the next one or give up
                  step_ff <= STEP_SDA_MAX;
                  if (p_ff == i2cts_pkg::PRESC_LAST) begin
                     status_ff <= i2cts_pkg::STATUS_NO_FIT;
                     state_ff  <= S_DONE;
                  end else begin
                     p_ff     <= p_ff + 1'b1;
                     tp_ff    <= tp_ff +
                                 {{(i2cts_pkg::ACC_W-i2cts_pkg::T_W){1'b0}}, t_ff};
                     state_ff <= S_LOAD;
                  end
               end else begin
                  case (step_ff)
                     STEP_SDA_MAX: begin
                        sda_max_ff <= quot;
                        step_ff    <= STEP_SDA_MIN;
                        state_ff   <= S_LOAD;
                     end
                     STEP_SDA_MIN: begin
                        sda_min_ff <= quot[3:0];
                        step_ff    <= STEP_SCL;
                        state_ff   <= S_LOAD;
                     end
                     STEP_SCL: begin
                        scl_ff   <= (quot == '0) ? 4'd0 : 4'(quot - 1'b1);
                        step_ff  <= STEP_HIGH;
                        state_ff <= S_LOAD;
                     end
                     STEP_HIGH: begin
                        nh_ff    <= quot;
                        step_ff  <= STEP_LOW;
                        state_ff <= S_LOAD;
                     end
                     STEP_LOW: begin
                        n_ff      <= n_max[7:0];
                        status_ff <= i2cts_pkg::STATUS_OK;
                        state_ff  <= S_DONE;
                     end
                     default: begin
                        step_ff  <= STEP_SDA_MAX;
                        state_ff <= S_LOAD;
                     end
                  endcase
               end
            end

            // hand the result to the output register once it is free
            S_DONE: begin
               if (rsp_load) begin
                  rsp_tdata_ff <= rsp_word;
                  state_ff     <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // a request starts work: no second request the cycle after
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while solver busy");

   // divider remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVT || state_ff == S_DIV) |-> (div_rem_ff < div_den))
      else $error("divider remainder out of range");

   // failed responses carry only the status
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != i2cts_pkg::STATUS_OK) |->
      (rsp_tdata[i2cts_pkg::RSP_DATA_W-1:2] == '0))
      else $error("failure response with nonzero fields");

   // solved responses: fields agree with the packed word
   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == i2cts_pkg::STATUS_OK) |->
      (rsp_tdata[53:46] == rsp_tdata[61:54] && rsp_tdata[33:30] == rsp_tdata[37:34] &&
       rsp_tdata[25:22] == rsp_tdata[41:38] && rsp_tdata[21:18] == rsp_tdata[45:42] &&
       rsp_tdata[17:10] == rsp_tdata[53:46] && rsp_tdata[29:26] == 4'd0))
      else $error("timing word disagrees with fields");
`endif

endmodule
